FILE: hw/rtl/kci_pkg.sv
// Shared types and constants for the keyframe curve interpolator.
package kci_pkg;

    localparam int DEF_MAX_POINTS = 64;

    // Point memory word: {linear flag, y, x}
    localparam int RAM_W = 65;

    // Iterative divider operand widths
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 35;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH    = 2'd2;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [5:0]         point_slot;
        logic signed [31:0] position;
        logic signed [31:0] level;
        logic               segment_linear;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic               result_linear;
    } t_out_item;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] num;
        logic signed [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                        done;
        logic signed [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

FILE: hw/rtl/kci_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kci_ram #(
    parameter int WIDTH = kci_pkg::RAM_W,
    parameter int DEPTH = kci_pkg::DEF_MAX_POINTS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/kci_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module kci_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kci_pkg::t_div_req i_req,
    output kci_pkg::t_div_rsp o_rsp
);
    import kci_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_dmag;
    logic [DIV_DEN_W-1:0] r_rem;

    logic [DIV_NUM_W-1:0] num_mag;
    logic [DIV_DEN_W-1:0] den_mag;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    always_comb begin
        num_mag = i_req.num[DIV_NUM_W-1] ? DIV_NUM_W'(-i_req.num) : DIV_NUM_W'(i_req.num);
        den_mag = i_req.den[DIV_DEN_W-1] ? DIV_DEN_W'(-i_req.den) : DIV_DEN_W'(i_req.den);
        trial   = {r_rem, r_quo[DIV_NUM_W-1]};
        diff    = trial - {1'b0, r_dmag};
        fits    = (trial >= {1'b0, r_dmag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
                r_quo  <= num_mag;
                r_dmag <= den_mag;
                r_rem  <= '0;
                r_neg  <= i_req.num[DIV_NUM_W-1] ^ i_req.den[DIV_DEN_W-1];
            end else if (r_busy) begin
                r_rem <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

FILE: hw/rtl/keyframe_curve_interpolator.sv
// Keyframe curve interpolator: point table in RAM, binary search, linear or cubic segment.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+----------------------
//   input    | in        | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//   result   | out       | o_out_valid / i_out_stall | o_out_item (t_out_item)
//   config   | in        | i_cfg_we, i_cfg_index     | i_cfg_data (32 bit)
//
// A point write is taken in S_IDLE and yields no result. An evaluate runs the
// binary search, each probe passing through S_SRCH and S_SCMP (registered RAM
// read), then either ends at once (empty table, outside the points), runs a
// linear segment (one divide and one multiply) or a cubic segment (three
// divides, five multiplies) on the serial divider and the split multiplier.
// Reset clears control state only; table contents are undefined until written.
// A finished result waits in the output register while the next item is taken.
module keyframe_curve_interpolator #(
    parameter int MAX_POINTS = kci_pkg::DEF_MAX_POINTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  kci_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output kci_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [kci_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    import kci_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);          // RAM address
    localparam int CW = $clog2(MAX_POINTS + 1);      // search bounds, 0..n
    localparam int PW = (CW > 7) ? CW : 7;           // count compare width
    localparam int SW = (AW > 6) ? AW + 1 : 7;       // slot compare width

    typedef logic signed [47:0] t_wide;

    localparam t_wide IM_LIM   = 48'sd137438953471;  // 2^37 - 1
    localparam t_wide NEAR_GAP = 48'sd655;           // 0.01 in Q16.16
    localparam t_wide I32_MAX  = 48'sd2147483647;
    localparam t_wide I32_MIN  = -48'sd2147483648;
    localparam logic signed [63:0] ONE_R = 64'sd1073741824;   // 1.0 in Q.30
    localparam logic signed [63:0] ONE_S = 64'sd67108864;     // 1.0 in Q.26
    localparam logic signed [63:0] R_MAX = 64'sd2147483648;   // 2.0 in Q.30
    localparam int R_FRAC = 30;
    localparam int S_FRAC = 26;

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH, S_SCMP, S_FCMP, S_LOC, S_EDGE,
        S_G1, S_G2, S_G0, S_G3, S_ADJ,
        S_DIV, S_MUL, S_MSH,
        S_LT, S_LF,
        S_T1L, S_T1R, S_T1P, S_T2R, S_T2P, S_SR,
        S_H1, S_H2, S_H3, S_PUSH
    } t_state;

    function automatic t_wide f_lim(input t_wide v);
        t_wide r;
        r = v;
        if (v > IM_LIM) r = IM_LIM;
        else if (v < -IM_LIM) r = -IM_LIM;
        return r;
    endfunction

    function automatic logic signed [63:0] f_clamp(input logic signed [63:0] v,
                                                  input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
        logic signed [63:0] r;
        r = v;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        return r;
    endfunction

    function automatic logic [36:0] f_mag37(input t_wide v);
        t_wide m;
        m = (v < 0) ? -v : v;
        return m[36:0];
    endfunction

    function automatic logic [31:0] f_mag32(input t_wide v);
        t_wide m;
        m = (v < 0) ? -v : v;
        return m[31:0];
    endfunction

    // ---------------------------------------------------------------- state
    t_state             r_state, r_ret;
    logic [6:0]         r_pts;
    logic signed [31:0] r_clo, r_chi;
    logic [CW-1:0]      r_lo, r_hi, r_mid, r_n;
    logic signed [31:0] r_q, r_x1, r_y1, r_x2, r_y2, r_x0, r_y0, r_x3, r_y3;
    logic               r_lin1;
    t_wide              r_d, r_dy, r_den1, r_den2, r_dya, r_dyb;
    t_wide              r_t1, r_t2, r_b, r_s, r_prod;
    logic signed [63:0] r_quo;
    logic [36:0]        r_ma;
    logic [31:0]        r_mb;
    logic               r_mneg, r_msh, r_mph;
    logic [68:0]        r_acc;
    t_out_item          r_res, r_out;
    logic               r_ovalid;
    t_div_req           r_dreq;

    t_div_rsp           div_rsp;

    // RAM ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [RAM_W-1:0]   ram_wdata, ram_rdata;
    logic signed [31:0] rd_x, rd_y;
    logic               rd_lin;

    // ---------------------------------------------------------- comb logic
    logic               in_xfer;
    logic [SW-1:0]      slot_ext;
    logic [PW-1:0]      pts_ext;
    logic [CW-1:0]      n_count;
    logic [CW:0]        lohi_sum;
    logic [CW-1:0]      srch_mid, rd_idx;
    t_wide              q_x1, g2_d, g2_dy, x0_adj, x3_adj;
    logic               g2_near;
    logic signed [63:0] quo_r, quo_t, quo_s;
    t_wide              coef_a, coef_b;
    logic [68:0]        mul_shr;
    t_wide              mul_mag, mul_res;
    t_wide              lin_y, cub_y;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign slot_ext = SW'(i_in_item.point_slot);
    assign pts_ext  = PW'(r_pts);
    // counts above the table size act as the table size
    assign n_count  = (pts_ext > PW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pts_ext);
    assign lohi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign srch_mid = lohi_sum[CW:1];

    assign ram_we    = in_xfer && (i_in_item.operation == OP_WRITE)
                       && (slot_ext < SW'(MAX_POINTS));
    assign ram_waddr = slot_ext[AW-1:0];
    assign ram_wdata = {i_in_item.segment_linear, i_in_item.level, i_in_item.position};
    assign rd_x      = $signed(ram_rdata[31:0]);
    assign rd_y      = $signed(ram_rdata[63:32]);
    assign rd_lin    = ram_rdata[64];

    // Read address: issued one state ahead of the state that uses the data.
    always_comb begin
        unique case (r_state)
            S_SRCH:  rd_idx = (r_lo < r_hi) ? srch_mid : r_lo;
            S_LOC: begin
                if (r_lo == '0)        rd_idx = '0;
                else if (r_lo >= r_n)  rd_idx = r_n - CW'(1);
                else                   rd_idx = r_lo - CW'(1);      // p1
            end
            S_G1:    rd_idx = r_lo;                                  // p2
            S_G2:    rd_idx = (r_lo >= CW'(2)) ? r_lo - CW'(2) : r_lo - CW'(1); // p0
            S_G0:    rd_idx = ((r_lo + CW'(1)) < r_n) ? r_lo + CW'(1) : r_lo; // p3
            default: rd_idx = '0;
        endcase
    end
    assign ram_raddr = rd_idx[AW-1:0];

    always_comb begin
        q_x1    = 48'(r_q) - 48'(r_x1);
        g2_d    = 48'(rd_x) - 48'(r_x1);
        g2_dy   = 48'(rd_y) - 48'(r_y1);
        g2_near = (g2_d >= -NEAR_GAP) && (g2_d <= NEAR_GAP);
        // end neighbors that sit on the segment ends are pushed out by 0.01
        x0_adj  = 48'(r_x0);
        if (((48'(r_x0) - 48'(r_x1)) >= -NEAR_GAP) && ((48'(r_x0) - 48'(r_x1)) <= NEAR_GAP))
            x0_adj = 48'(r_x1) - NEAR_GAP;
        x3_adj  = 48'(r_x3);
        if (((48'(r_x2) - 48'(r_x3)) >= -NEAR_GAP) && ((48'(r_x2) - 48'(r_x3)) <= NEAR_GAP))
            x3_adj = 48'(r_x2) + NEAR_GAP;
        quo_r   = f_clamp(r_quo, -R_MAX, R_MAX);
        quo_t   = f_clamp(r_quo, 64'sd0, ONE_R);
        quo_s   = f_clamp(r_quo, 64'sd0, ONE_S);
        coef_a  = f_lim(r_t1 + r_t2 - (r_dy <<< 1));
        coef_b  = f_lim((r_dy <<< 1) + r_dy - (r_t1 <<< 1) - r_t2);
        // product magnitude shifted, then signed: truncation toward zero
        mul_shr = r_msh ? (r_acc >> R_FRAC) : (r_acc >> S_FRAC);
        mul_mag = mul_shr[47:0];
        mul_res = r_mneg ? -mul_mag : mul_mag;
        lin_y   = 48'(r_y1) + r_prod;
        if (lin_y > I32_MAX) lin_y = I32_MAX;
        else if (lin_y < I32_MIN) lin_y = I32_MIN;
        cub_y   = 48'(r_y1) + r_prod;
        if (cub_y < 48'(r_clo)) cub_y = 48'(r_clo);
        if (cub_y > 48'(r_chi)) cub_y = 48'(r_chi);
        if (cub_y > I32_MAX) cub_y = I32_MAX;
        else if (cub_y < I32_MIN) cub_y = I32_MIN;
    end

    // ------------------------------------------------------------ sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_pts        <= '0;
            r_clo        <= 32'sh8000_0000;
            r_chi        <= 32'sh7fff_ffff;
            r_dreq.start <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POINTS_IN_USE: r_pts <= i_cfg_data[6:0];
                    CFG_CLAMP_LOW:     r_clo <= $signed(i_cfg_data);
                    CFG_CLAMP_HIGH:    r_chi <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            // output register: loaded from S_PUSH, emptied by a transfer
            if ((r_state == S_PUSH) && (!r_ovalid || !i_out_stall)) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_out_stall)                       r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_in_item.operation == OP_EVAL)) begin
                        r_q <= i_in_item.position;
                        r_n <= n_count;
                        if (n_count == '0) begin
                            r_res   <= '0;           // empty table
                            r_state <= S_PUSH;
                        end else begin
                            r_lo    <= '0;
                            r_hi    <= n_count - CW'(1);
                            r_state <= S_SRCH;
                        end
                    end
                end
                // upper-bound search: lo ends on the first x above the query
                S_SRCH: begin
                    r_mid   <= srch_mid;
                    r_state <= (r_lo < r_hi) ? S_SCMP : S_FCMP;
                end
                S_SCMP: begin
                    if (rd_x <= r_q) r_lo <= r_mid + CW'(1);
                    else             r_hi <= r_mid;
                    r_state <= S_SRCH;
                end
                S_FCMP: begin
                    if (rd_x <= r_q) r_lo <= r_lo + CW'(1);
                    r_state <= S_LOC;
                end
                S_LOC: begin
                    r_state <= ((r_lo == '0) || (r_lo >= r_n)) ? S_EDGE : S_G1;
                end
                // query before the first or after the last point
                S_EDGE: begin
                    r_res.curve_value   <= rd_y;
                    r_res.result_linear <= rd_lin;
                    r_state             <= S_PUSH;
                end
                S_G1: begin
                    r_x1    <= rd_x;
                    r_y1    <= rd_y;
                    r_lin1  <= rd_lin;
                    r_state <= S_G2;
                end
                S_G2: begin
                    r_x2 <= rd_x;
                    r_y2 <= rd_y;
                    r_d  <= g2_d;
                    r_dy <= g2_dy;
                    if (r_lin1 || g2_near) begin
                        if (g2_d == '0) begin
                            r_quo   <= '0;
                            r_state <= S_LT;
                        end else begin
                            r_dreq.start <= 1'b1;
                            r_dreq.num   <= 64'(q_x1) <<< R_FRAC;
                            r_dreq.den   <= 35'(g2_d);
                            r_ret        <= S_LT;
                            r_state      <= S_DIV;
                        end
                    end else begin
                        r_state <= S_G0;
                    end
                end
                S_G0: begin
                    r_x0    <= rd_x;
                    r_y0    <= rd_y;
                    r_state <= S_G3;
                end
                S_G3: begin
                    r_x3    <= rd_x;
                    r_y3    <= rd_y;
                    r_state <= S_ADJ;
                end
                S_ADJ: begin
                    r_den1  <= 48'(r_x2) - x0_adj;
                    r_den2  <= x3_adj - 48'(r_x1);
                    r_dya   <= 48'(r_y2) - 48'(r_y0);
                    r_dyb   <= 48'(r_y3) - 48'(r_y1);
                    r_state <= S_T1L;
                end
                // start pulse lasts the first cycle here only
                S_DIV: begin
                    r_dreq.start <= 1'b0;
                    if (div_rsp.done) begin
                        r_quo   <= div_rsp.quo;
                        r_state <= r_ret;
                    end
                end
                // 37x32 multiply as two 37x16 partial products
                S_MUL: begin
                    if (!r_mph) begin
                        r_acc <= 69'(r_ma * r_mb[15:0]);
                        r_mph <= 1'b1;
                    end else begin
                        r_acc   <= r_acc + (69'(r_ma * r_mb[31:16]) << 16);
                        r_mph   <= 1'b0;
                        r_state <= S_MSH;
                    end
                end
                S_MSH: begin
                    r_prod  <= mul_res;
                    r_state <= r_ret;
                end
                // linear segment
                S_LT: begin
                    r_ma    <= f_mag37(r_dy);
                    r_mb    <= 32'(quo_t);
                    r_mneg  <= r_dy[47];
                    r_msh   <= 1'b1;
                    r_mph   <= 1'b0;
                    r_ret   <= S_LF;
                    r_state <= S_MUL;
                end
                S_LF: begin
                    r_res.curve_value   <= lin_y[31:0];
                    r_res.result_linear <= 1'b1;
                    r_state             <= S_PUSH;
                end
                // cubic segment: tangent at p1
                S_T1L: begin
                    if (r_den1 == '0) begin
                        r_quo   <= '0;
                        r_state <= S_T1R;
                    end else begin
                        r_dreq.start <= 1'b1;
                        r_dreq.num   <= 64'(r_d) <<< R_FRAC;
                        r_dreq.den   <= 35'(r_den1);
                        r_ret        <= S_T1R;
                        r_state      <= S_DIV;
                    end
                end
                S_T1R: begin
                    r_ma    <= f_mag37(r_dya);
                    r_mb    <= f_mag32(48'(quo_r));
                    r_mneg  <= r_dya[47] ^ quo_r[63];
                    r_msh   <= 1'b1;
                    r_mph   <= 1'b0;
                    r_ret   <= S_T1P;
                    r_state <= S_MUL;
                end
                // tangent at p2
                S_T1P: begin
                    r_t1 <= f_lim(r_prod);
                    if (r_den2 == '0) begin
                        r_quo   <= '0;
                        r_state <= S_T2R;
                    end else begin
                        r_dreq.start <= 1'b1;
                        r_dreq.num   <= 64'(r_d) <<< R_FRAC;
                        r_dreq.den   <= 35'(r_den2);
                        r_ret        <= S_T2R;
                        r_state      <= S_DIV;
                    end
                end
                S_T2R: begin
                    r_ma    <= f_mag37(r_dyb);
                    r_mb    <= f_mag32(48'(quo_r));
                    r_mneg  <= r_dyb[47] ^ quo_r[63];
                    r_msh   <= 1'b1;
                    r_mph   <= 1'b0;
                    r_ret   <= S_T2P;
                    r_state <= S_MUL;
                end
                // segment parameter s in Q.26
                S_T2P: begin
                    r_t2         <= f_lim(r_prod);
                    r_dreq.start <= 1'b1;
                    r_dreq.num   <= 64'(q_x1) <<< S_FRAC;
                    r_dreq.den   <= 35'(r_d);
                    r_ret        <= S_SR;
                    r_state      <= S_DIV;
                end
                // Horner: ((a s + b) s + t1) s + y1
                S_SR: begin
                    r_s     <= 48'(quo_s);
                    r_b     <= coef_b;
                    r_ma    <= f_mag37(coef_a);
                    r_mb    <= 32'(quo_s);
                    r_mneg  <= coef_a[47];
                    r_msh   <= 1'b0;
                    r_mph   <= 1'b0;
                    r_ret   <= S_H1;
                    r_state <= S_MUL;
                end
                S_H1: begin
                    r_ma    <= f_mag37(f_lim(r_b + r_prod));
                    r_mb    <= f_mag32(r_s);
                    r_mneg  <= f_lim(r_b + r_prod) < 0;
                    r_msh   <= 1'b0;
                    r_mph   <= 1'b0;
                    r_ret   <= S_H2;
                    r_state <= S_MUL;
                end
                S_H2: begin
                    r_ma    <= f_mag37(f_lim(r_t1 + r_prod));
                    r_mb    <= f_mag32(r_s);
                    r_mneg  <= f_lim(r_t1 + r_prod) < 0;
                    r_msh   <= 1'b0;
                    r_mph   <= 1'b0;
                    r_ret   <= S_H3;
                    r_state <= S_MUL;
                end
                S_H3: begin
                    r_res.curve_value   <= cub_y[31:0];
                    r_res.result_linear <= 1'b0;
                    r_state             <= S_PUSH;
                end
                // hand the result to the output register once it is free
                S_PUSH: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out    <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------ instances
    kci_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    kci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (div_rsp)
    );

    // ----------------------------------------------------------- assertions
`ifndef SYNTHESIS
    a_div_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished while sequencer not waiting");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("table write outside idle");

    a_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && r_ovalid && i_out_stall) |=> (r_state == S_PUSH))
        else $error("result pushed over a stalled output");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_hi < r_n))
        else $error("search bound beyond point count");
`endif

endmodule

FILE: tb/sv/tb_keyframe_curve_interpolator.sv
// Self-checking testbench for keyframe_curve_interpolator: directed table, then random phases.
module tb_keyframe_curve_interpolator;
    import kci_pkg::*;

    localparam int        N_SLOTS   = DEF_MAX_POINTS;
    localparam int        NEAR_GAP  = 655;
    localparam int        RAND_ITEMS = 600;
    localparam int        SETTLE    = 400;   // above the slowest cubic evaluate
    localparam int        HOLD_LEN  = 3000;  // long receiver hold-off, in cycles
    localparam longint    I32_MAX   = (64'sd1 <<< 31) - 1;
    localparam longint    I32_MIN   = -(64'sd1 <<< 31);
    localparam longint    IM_LIM    = (64'sd1 <<< 37) - 1;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        t_in_item                item;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [31:0]             reg_val;
        bit                      typed;
        t_out_item               want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_POINTS_IN_USE;
    logic [31:0]          i_cfg_data = '0;

    keyframe_curve_interpolator dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the point table and registers
    logic signed [31:0] pt_x [N_SLOTS];
    logic signed [31:0] pt_y [N_SLOTS];
    bit                 pt_lin [N_SLOTS];
    bit                 pt_written [N_SLOTS];
    int unsigned        used_pts = 0;
    logic signed [31:0] clip_lo = 32'sh8000_0000;
    logic signed [31:0] clip_hi = 32'sh7fff_ffff;

    t_out_item curve_q [$];     // expected evaluate results, oldest first
    int  n_errors = 0;
    int  n_items = 0;
    int  n_evals = 0;
    int  n_lin_res = 0;
    int  n_cfg = 0;
    bit  hold_req = 1'b0;

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint shr_tz(longint v, int n);
        longint m;
        m = v < 0 ? -v : v;
        m = m >>> n;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint slope(longint d, longint dy, longint den);
        longint r;
        if (den == 0) return 0;
        r = sat((d * (64'sd1 <<< 30)) / den, -(64'sd1 <<< 31), 64'sd1 <<< 31);
        return shr_tz(dy * r, 30);
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    // curve value at query position q, from the shadow table
    function automatic t_out_item eval_curve(logic signed [31:0] qv);
        t_out_item   res;
        int unsigned n, lo, hi, mid, i0, i1, i2, i3;
        longint q, y, x0, x1, x2, x3, y0, y1, y2, y3, d, dy, t, t1, t2, s, a, b, h;
        q   = qv;
        res = '0;
        n   = used_pts > N_SLOTS ? N_SLOTS : used_pts;
        if (n == 0) return res;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (longint'(pt_x[mid]) <= q) lo = mid + 1;
            else hi = mid;
        end
        if (longint'(pt_x[lo]) <= q) lo++;
        if (lo == 0) begin
            res.curve_value   = pt_y[0];
            res.result_linear = pt_lin[0];
            return res;
        end
        if (lo >= n) begin
            res.curve_value   = pt_y[n-1];
            res.result_linear = pt_lin[n-1];
            return res;
        end
        i2 = lo;
        i1 = lo - 1;
        x1 = pt_x[i1];  x2 = pt_x[i2];
        y1 = pt_y[i1];  y2 = pt_y[i2];
        d  = x2 - x1;
        dy = y2 - y1;
        if (pt_lin[i1] || absl(d) <= NEAR_GAP) begin
            t = 0;
            if (d != 0) t = sat(((q - x1) * (64'sd1 <<< 30)) / d, 0, 64'sd1 <<< 30);
            y = sat(y1 + shr_tz(dy * t, 30), I32_MIN, I32_MAX);
            res.curve_value   = y[31:0];
            res.result_linear = 1'b1;
            return res;
        end
        // cubic segment; end neighbors pushed out by the near gap
        i0 = i1 > 0 ? i1 - 1 : i1;
        i3 = i2 + 1 < n ? i2 + 1 : i2;
        x0 = pt_x[i0];  x3 = pt_x[i3];
        y0 = pt_y[i0];  y3 = pt_y[i3];
        if (absl(x0 - x1) <= NEAR_GAP) x0 = x1 - NEAR_GAP;
        if (absl(x2 - x3) <= NEAR_GAP) x3 = x2 + NEAR_GAP;
        t1 = sat(slope(d, y2 - y0, x2 - x0), -IM_LIM, IM_LIM);
        t2 = sat(slope(d, y3 - y1, x3 - x1), -IM_LIM, IM_LIM);
        s  = sat(((q - x1) * (64'sd1 <<< 26)) / d, 0, 64'sd1 <<< 26);
        a  = sat(t1 + t2 - 2 * dy, -IM_LIM, IM_LIM);
        b  = sat(3 * dy - 2 * t1 - t2, -IM_LIM, IM_LIM);
        h  = sat(b + shr_tz(a * s, 26), -IM_LIM, IM_LIM);
        h  = sat(t1 + shr_tz(h * s, 26), -IM_LIM, IM_LIM);
        y  = y1 + shr_tz(h * s, 26);
        if (y < longint'(clip_lo)) y = clip_lo;
        if (y > longint'(clip_hi)) y = clip_hi;
        y  = sat(y, I32_MIN, I32_MAX);
        res.curve_value   = y[31:0];
        res.result_linear = 1'b0;
        return res;
    endfunction

    // random gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(5, 15);
        return $urandom_range(40, 100);
    endfunction

    // offer one item; returns after the transfer, updating the shadow state
    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        n_items++;
        if (it.operation == OP_WRITE) begin
            pt_x[it.point_slot]       = it.position;
            pt_y[it.point_slot]       = it.level;
            pt_lin[it.point_slot]     = it.segment_linear;
            pt_written[it.point_slot] = 1'b1;
        end else begin
            n_evals++;
            curve_q.push_back(typed ? want : eval_curve(it.position));
        end
    endtask

    // sender pause: every expected result in, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (curve_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_cfg++;
        case (idx)
            CFG_POINTS_IN_USE: used_pts = val[6:0];
            CFG_CLAMP_LOW:     clip_lo  = val;
            CFG_CLAMP_HIGH:    clip_hi  = val;
            default: ;
        endcase
    endtask

    function automatic t_in_item mk_item(logic op, int slot, logic signed [31:0] pos,
                                         logic signed [31:0] lvl, logic lin);
        t_in_item it;
        it.operation      = op;
        it.point_slot     = slot[5:0];
        it.position       = pos;
        it.level          = lvl;
        it.segment_linear = lin;
        return it;
    endfunction

    function automatic t_dir_row row_item(t_in_item it, bit typed, logic signed [31:0] v,
                                          logic lin);
        t_dir_row r;
        r.kind    = ROW_ITEM;
        r.item    = it;
        r.reg_idx = CFG_POINTS_IN_USE;
        r.reg_val = '0;
        r.typed   = typed;
        r.want.curve_value   = v;
        r.want.result_linear = lin;
        return r;
    endfunction

    function automatic t_dir_row row_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        t_dir_row r;
        r         = row_item('0, 1'b0, '0, 1'b0);
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // number of slots written without a hole from slot 0
    function automatic int written_prefix();
        int k;
        k = 0;
        while (k < N_SLOTS && pt_written[k]) k++;
        return k;
    endfunction

    function automatic logic signed [31:0] rand_level();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    // receiver: random stalls plus one long hold-off when asked
    initial begin : out_stall_gen
        int run;
        run = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
                run = 0;
            end else if (run > 0) begin
                run--;
            end else begin
                case ($urandom_range(0, 19))
                    0:          begin i_out_stall <= 1'b1; run = $urandom_range(20, 80); end
                    1, 2, 3, 4: begin i_out_stall <= 1'b1; run = $urandom_range(0, 3); end
                    default:    begin i_out_stall <= 1'b0; run = $urandom_range(0, 30); end
                endcase
            end
        end
    end

    // result checker: each transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (curve_q.size() == 0) begin
                $error("unexpected result: curve_value %0d result_linear %0d",
                       o_out_item.curve_value, o_out_item.result_linear);
                n_errors++;
            end else begin
                want = curve_q.pop_front();
                if (o_out_item.result_linear) n_lin_res++;
                if (o_out_item.curve_value !== want.curve_value) begin
                    $error("curve_value: expected %0d, actual %0d",
                           want.curve_value, o_out_item.curve_value);
                    n_errors++;
                end
                if (o_out_item.result_linear !== want.result_linear) begin
                    $error("result_linear: expected %0d, actual %0d",
                           want.result_linear, o_out_item.result_linear);
                    n_errors++;
                end
            end
        end
    end

    initial begin : watchdog
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_dir_row  tab [$];
        t_out_item none;
        int        k, n_target, cnt, j, phase, mode;
        longint    xacc;
        logic signed [31:0] qv, lo_v, hi_v;

        none = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, ends, linear, near gap, cubic, clamps
        tab.push_back(row_item(mk_item(OP_EVAL, 0, 0, 0, 0), 1, 0, 0));
        tab.push_back(row_item(mk_item(OP_EVAL, 63, 32'sh7fff_ffff, 32'sh7fff_ffff, 1), 1, 0, 0));
        tab.push_back(row_item(mk_item(OP_WRITE, 0, -10 * ONE, ONE, 1), 0, 0, 0));
        tab.push_back(row_item(mk_item(OP_WRITE, 1, 0, 2 * ONE, 0), 0, 0, 0));
        tab.push_back(row_item(mk_item(OP_WRITE, 2, 32'sh100, 3 * ONE, 0), 0, 0, 0));
        tab.push_back(row_item(mk_item(OP_WRITE, 3, 5 * ONE, -4 * ONE, 0), 0, 0, 0));
        tab.push_back(row_item(mk_item(OP_WRITE, 4, 10 * ONE, 32'sh7fff_ffff, 1), 0, 0, 0));
        tab.push_back(row_item(mk_item(OP_WRITE, 63, 32'sh7fff_ffff, 32'sh8000_0000, 1),
                               0, 0, 0));
        tab.push_back(row_reg(CFG_POINTS_IN_USE, 5));
        tab.push_back(row_item(mk_item(OP_EVAL, 0, 32'sh8000_0000, 0, 0), 1, ONE, 1));
        tab.push_back(row_item(mk_item(OP_EVAL, 0, 32'sh7fff_ffff, 0, 0), 1,
                               32'sh7fff_ffff, 1));
        tab.push_back(row_item(mk_item(OP_EVAL, 0, -5 * ONE, 0, 0), 0, 0, 0));
        tab.push_back(row_item(mk_item(OP_EVAL, 0, 32'sh80, 0, 0), 0, 0, 0));
        tab.push_back(row_item(mk_item(OP_EVAL, 0, 0, 0, 0), 0, 0, 0));
        tab.push_back(row_item(mk_item(OP_EVAL, 0, 2 * ONE, 0, 0), 0, 0, 0));
        tab.push_back(row_item(mk_item(OP_EVAL, 0, 7 * ONE, 0, 0), 0, 0, 0));
        tab.push_back(row_reg(CFG_CLAMP_LOW, -ONE));
        tab.push_back(row_reg(CFG_CLAMP_HIGH, ONE));
        tab.push_back(row_item(mk_item(OP_EVAL, 0, 2 * ONE, 0, 0), 0, 0, 0));
        tab.push_back(row_item(mk_item(OP_EVAL, 0, 7 * ONE, 0, 0), 0, 0, 0));
        tab.push_back(row_reg(CFG_CLAMP_LOW, 32'h8000_0000));
        tab.push_back(row_reg(CFG_CLAMP_HIGH, 32'h7fff_ffff));

        foreach (tab[i]) begin
            if (tab[i].kind == ROW_CFG) begin
                drain();
                reg_write(tab[i].reg_idx, tab[i].reg_val);
            end else begin
                send_item(tab[i].item, tab[i].typed, tab[i].want);
            end
        end

        // random phases: load a table, set registers while idle, then evaluate
        n_target = n_items + RAND_ITEMS;
        phase = 0;
        while (n_items < n_target) begin
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 64) : $urandom_range(2, 12);
            mode = $urandom_range(0, 4);
            xacc = longint'($signed($urandom)) >>> $urandom_range(1, 8);
            for (int s = 0; s < k; s++) begin
                if (mode == 0) begin
                    qv = $urandom;              // unsorted table
                end else begin
                    qv = 32'(sat(xacc, I32_MIN, I32_MAX));
                    case ($urandom_range(0, 5))
                        0:       xacc += $urandom_range(0, NEAR_GAP);
                        1:       xacc += $urandom_range(NEAR_GAP + 1, 32'h0004_0000);
                        2:       xacc += $urandom_range(0, 32'h1000_0000);
                        default: xacc += $urandom_range(32'h0001_0000, 32'h0080_0000);
                    endcase
                end
                send_item(mk_item(OP_WRITE, s, qv, rand_level(), $urandom_range(0, 3) == 0),
                          0, none);
            end
            drain();

            j = written_prefix();
            case ($urandom_range(0, 9))
                0:       reg_write(CFG_POINTS_IN_USE, 0);
                1:       reg_write(CFG_POINTS_IN_USE, 1);
                default: begin
                    if (j == N_SLOTS && $urandom_range(0, 2) == 0)
                        reg_write(CFG_POINTS_IN_USE, $urandom_range(64, 127));
                    else
                        reg_write(CFG_POINTS_IN_USE, $urandom_range(2, j));
                end
            endcase
            case ($urandom_range(0, 3))
                0: begin lo_v = 32'sh8000_0000; hi_v = 32'sh7fff_ffff; end
                1: begin
                    lo_v = -$signed($urandom_range(0, 32'h0040_0000));
                    hi_v = $signed($urandom_range(0, 32'h0040_0000));
                end
                2: begin lo_v = $urandom; hi_v = $urandom; end
                default: begin lo_v = 32'sh7fff_ffff; hi_v = 32'sh8000_0000; end
            endcase
            reg_write(CFG_CLAMP_LOW, lo_v);
            reg_write(CFG_CLAMP_HIGH, hi_v);

            // one phase with the receiver held off so the block backs up
            if (phase == 3) hold_req = 1'b1;

            cnt = $urandom_range(8, 30);
            for (int e = 0; e < cnt; e++) begin
                j = $urandom_range(0, k - 1);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: qv = pt_x[j] + $signed($urandom_range(0, 32'h0004_0000))
                                     - $signed($urandom_range(0, 32'h0000_1000));
                    4, 5:       qv = pt_x[j];
                    6, 7:       qv = pt_x[j] + ((pt_x[$urandom_range(0, k - 1)] - pt_x[j]) >>> 1);
                    8:          qv = $urandom;
                    default:    qv = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
                endcase
                send_item(mk_item(OP_EVAL, $urandom_range(0, 63), qv, $urandom,
                                  1'($urandom_range(0, 1))), 0, none);
                // occasional in-flight point rewrite, any slot
                if ($urandom_range(0, 9) == 0)
                    send_item(mk_item(OP_WRITE, $urandom_range(0, 63), $urandom, rand_level(),
                                      1'($urandom_range(0, 1))), 0, none);
            end
            drain();
            phase++;
        end

        drain();
        $display("run covered %0d transfers in, %0d evaluations (%0d linear results)",
                 n_items, n_evals, n_lin_res);
        $display("%0d register writes over %0d random table phases", n_cfg, phase);
        if (n_errors == 0 && curve_q.size() == 0) begin
            $display("tb: success");
        end else begin
            if (curve_q.size() != 0)
                $error("%0d expected results never arrived", curve_q.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
